// ===== rtl/core/tea_block_cipher_top_assert.svh =====
// assertion helpers shared by the cipher top level
`ifndef TEA_BLOCK_CIPHER_TOP_ASSERT_SVH
`define TEA_BLOCK_CIPHER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TEA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define TEA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tea_pkg.sv =====
package tea_pkg;

	localparam int unsigned TEA_ROUNDS    = 32;
	localparam int unsigned TEA_CFG_IDX_W = 8;
	localparam logic [31:0] TEA_DELTA     = 32'h9e37_79b9;

	// configuration register indexes
	localparam logic [TEA_CFG_IDX_W-1:0] REG_KEY0 = TEA_CFG_IDX_W'(0);
	localparam logic [TEA_CFG_IDX_W-1:0] REG_KEY1 = TEA_CFG_IDX_W'(1);
	localparam logic [TEA_CFG_IDX_W-1:0] REG_KEY2 = TEA_CFG_IDX_W'(2);
	localparam logic [TEA_CFG_IDX_W-1:0] REG_KEY3 = TEA_CFG_IDX_W'(3);

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} tea_op_t;

	typedef struct packed {
		tea_op_t     op;
		logic [31:0] left_in;
		logic [31:0] right_in;
	} tea_in_t;

	typedef struct packed {
		logic [31:0] left_out;
		logic [31:0] right_out;
	} tea_out_t;

	// block in flight between half-rounds
	typedef struct packed {
		tea_op_t     op;
		logic [31:0] left;
		logic [31:0] right;
	} tea_blk_t;

	typedef struct packed {
		logic [31:0] k0;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] k3;
	} tea_key_t;

endpackage

// ===== rtl/core/tea_key_regs.sv =====
module tea_key_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tea_pkg::TEA_CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                           cfg_data,
	output tea_pkg::tea_key_t                     key
);
	import tea_pkg::*;

	tea_key_t key_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY0: key_q.k0 <= cfg_data;
				REG_KEY1: key_q.k1 <= cfg_data;
				REG_KEY2: key_q.k2 <= cfg_data;
				REG_KEY3: key_q.k3 <= cfg_data;
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	assign key = key_q;

endmodule

// ===== rtl/core/tea_half_round.sv =====
module tea_half_round #(
	parameter int unsigned ROUNDS = tea_pkg::TEA_ROUNDS,
	parameter int unsigned IDX    = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tea_pkg::tea_key_t key,
	input  logic              up_valid,
	input  tea_pkg::tea_blk_t up_data,
	output logic              dn_valid,
	output tea_pkg::tea_blk_t dn_data
);
	import tea_pkg::*;

	localparam int unsigned ROUND   = IDX / 2;
	localparam logic        ODD     = 1'(IDX % 2);
	localparam logic [31:0] ENC_SUM = TEA_DELTA * 32'(ROUND + 1);
	localparam logic [31:0] DEC_SUM = TEA_DELTA * 32'(ROUNDS - ROUND);

	logic        enc;
	logic        upd_left;
	logic [31:0] x;
	logic [31:0] ka;
	logic [31:0] kb;
	logic [31:0] sum;
	logic [31:0] mix;
	logic [31:0] tgt;
	logic [31:0] upd;

	logic     valid_s1;
	tea_blk_t data_s1;

	// encrypt updates left first, decrypt runs the rounds backwards from right
	always_comb begin
		enc      = (up_data.op == OP_ENCRYPT);
		upd_left = enc ? !ODD : ODD;
		x        = upd_left ? up_data.right : up_data.left;
		ka       = upd_left ? key.k0 : key.k2;
		kb       = upd_left ? key.k1 : key.k3;
		sum      = enc ? ENC_SUM : DEC_SUM;
		mix      = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
		tgt      = upd_left ? up_data.left : up_data.right;
		upd      = enc ? tgt + mix : tgt - mix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1.op    <= up_data.op;
		data_s1.left  <= upd_left ? upd : up_data.left;
		data_s1.right <= upd_left ? up_data.right : upd;
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

// ===== rtl/core/tea_block_cipher_top.sv =====
// channel   signals                                  transfer when
// block     start, busy, item                        start && !busy
// result    result_valid, result                     result_valid (one cycle, no hold-off)
// key cfg   cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// one block enters per cycle; busy stays low
// each half-round is one register stage
// arst_n clears the key registers and every stage valid bit
// the result side cannot stall, so the pipeline never holds
`include "tea_block_cipher_top_assert.svh"

module tea_block_cipher_top #(
	parameter int unsigned ROUNDS = tea_pkg::TEA_ROUNDS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  tea_pkg::tea_in_t                  item,
	output logic                              result_valid,
	output tea_pkg::tea_out_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tea_pkg::TEA_CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                       cfg_data
);
	import tea_pkg::*;

	localparam int unsigned STAGES = 2 * ROUNDS;

	tea_key_t key;
	logic     chain_valid [0:STAGES];
	tea_blk_t chain_data  [0:STAGES];

	tea_key_regs u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key)
	);

	assign busy = 1'b0;

	assign chain_valid[0]      = start && !busy;
	assign chain_data[0].op    = item.op;
	assign chain_data[0].left  = item.left_in;
	assign chain_data[0].right = item.right_in;

	for (genvar g = 0; g < STAGES; g++) begin : g_half
		tea_half_round #(
			.ROUNDS (ROUNDS),
			.IDX    (g)
		) u_half (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key),
			.up_valid (chain_valid[g]),
			.up_data  (chain_data[g]),
			.dn_valid (chain_valid[g+1]),
			.dn_data  (chain_data[g+1])
		);
	end

	assign result_valid     = chain_valid[STAGES];
	assign result.left_out  = chain_data[STAGES].left;
	assign result.right_out = chain_data[STAGES].right;

	`TEA_ASSERT_NEXT(a_enter, start && !busy, chain_valid[1], "accepted block did not enter stage one")
	`TEA_ASSERT_NEXT(a_key0, cfg_valid && cfg_ready && cfg_index == REG_KEY0, key.k0 == $past(cfg_data), "key word 0 write lost")
	`TEA_ASSERT_IMP(a_strobe, result_valid, $past(chain_valid[STAGES-1]), "result strobe without a block in the last stage")

endmodule
